### design/csv_record_tokenizer_macros.svh
// Assertion macros for the tokenizer RTL.
`ifndef CSV_RECORD_TOKENIZER_MACROS_SVH
`define CSV_RECORD_TOKENIZER_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define CSVTOK_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define CSVTOK_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/csvtok_pkg.sv
// Types and codes shared by the CSV tokenizer modules.
`default_nettype none
package csvtok_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam logic [7:0] SEP_RESET   = 8'd44;
    localparam logic [7:0] COUNT_MAX   = 8'd255;

    localparam logic [2:0] M_IDLE   = 3'd0;
    localparam logic [2:0] M_SEP    = 3'd1;
    localparam logic [2:0] M_LEAD   = 3'd2;
    localparam logic [2:0] M_UNQ    = 3'd3;
    localparam logic [2:0] M_QUOTED = 3'd4;
    localparam logic [2:0] M_QCLOSE = 3'd5;
    localparam logic [2:0] M_POSTQ  = 3'd6;

    localparam logic [1:0] KIND_CHAR   = 2'd0;
    localparam logic [1:0] KIND_FIELD  = 2'd1;
    localparam logic [1:0] KIND_RECORD = 2'd2;
    localparam logic [1:0] KIND_STREAM = 2'd3;

    localparam logic REG_SEPARATOR = 1'b0;
    localparam logic REG_EXPECTED  = 1'b1;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] ch;
        logic       last;
    } res_t;

    // Results of one processed byte, core to queue.
    typedef struct packed {
        logic [1:0] n;
        res_t       e0;
        res_t       e1;
    } push_t;

endpackage
`default_nettype wire

### design/csvtok_if.sv
// Handshake channel interfaces for the tokenizer input and result streams.
`default_nettype none
interface csvtok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvtok_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_char;
    logic       last;

    modport source (output valid, output out_kind, output out_char, output last, input ready);
    modport sink (input valid, input out_kind, input out_char, input last, output ready);
endinterface
`default_nettype wire

### design/csv_record_tokenizer.sv
// CSV tokenizer top level: byte stream in, field/record/stream marks out.
// Usage:
//   rx carries one text byte per transfer (in_byte, end_of_input). A zero
//   byte or end_of_input closes the stream; later bytes are taken and dropped.
//   tx carries results: out_kind (content, end of field, end of field and
//   record, end of stream), out_char for content, last on the final result
//   of each input byte. A byte yields zero, one or two results.
//   Config port: cfg_we with cfg_index 0 (separator, reset comma) or
//   1 (expected fields, reset 0 = no limit); write only while idle.
// Timing:
//   A byte is held in the input register while it is decoded; its results
//   go into the result queue, which drives tx. One byte per cycle is
//   sustained while tx accepts and each byte yields at most one result; a
//   pair of results drains at one per cycle through the four-entry result
//   queue, which gates the decode stage when fewer than two entries are free.
//   When tx stalls, the queue fills, then the input register holds and
//   rx.ready drops. Reset clears the parse state, the queue and the config.
`default_nettype none
module csv_record_tokenizer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         cfg_we,
    input  wire         cfg_index,
    input  wire  [7:0]  cfg_wdata,
    csvtok_in_if.sink   rx,
    csvtok_out_if.source tx
);
    import csvtok_pkg::*;

    push_t push;
    res_t  out_res;
    logic  room;

    csvtok_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .in_valid  (rx.valid),
        .in_ready  (rx.ready),
        .in_byte   (rx.in_byte),
        .in_eoi    (rx.end_of_input),
        .room      (room),
        .push      (push)
    );

    csvtok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (tx.valid),
        .out_ready (tx.ready),
        .out_res   (out_res)
    );

    assign tx.out_kind = out_res.kind;
    assign tx.out_char = out_res.ch;
    assign tx.last     = out_res.last;

endmodule
`default_nettype wire

### design/csvtok_core.sv
// Input register, parse state and per-byte decode of the CSV tokenizer.
`default_nettype none
`include "csv_record_tokenizer_macros.svh"
module csvtok_core (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                cfg_we,
    input  wire                cfg_index,
    input  wire  [7:0]         cfg_wdata,
    input  wire                in_valid,
    output logic               in_ready,
    input  wire  [7:0]         in_byte,
    input  wire                in_eoi,
    input  wire                room,
    output csvtok_pkg::push_t  push
);
    import csvtok_pkg::*;

    logic [7:0] sep_reg, sep_next;
    logic [7:0] expf_reg, expf_next;
    logic       in_valid_reg, in_valid_next;
    logic [7:0] byte_reg, byte_next;
    logic       eoi_reg, eoi_next;
    logic [2:0] mode_reg, mode_next;
    logic [7:0] fc_reg, fc_next;
    logic       skip_reg, skip_next;
    logic       done_reg, done_next;

    logic       accept;
    logic       fire;
    logic       brk;
    logic       aq_go, open_go, lead_go, unq_go;
    logic [1:0] n;
    logic [1:0] kind_a [2];
    logic [7:0] char_a [2];

    assign in_ready = !in_valid_reg || room;
    assign accept   = in_valid && in_ready;
    assign fire     = in_valid_reg && room;
    assign brk      = (byte_reg == CH_CR) || (byte_reg == CH_LF);

    always_comb
    begin
        sep_next  = sep_reg;
        expf_next = expf_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_SEPARATOR: sep_next  = cfg_wdata;
                REG_EXPECTED:  expf_next = cfg_wdata;
                default:       sep_next  = sep_reg;
            endcase
        end
    end

    always_comb
    begin
        in_valid_next = in_valid_reg;
        byte_next     = byte_reg;
        eoi_next      = eoi_reg;
        if (accept)
        begin
            in_valid_next = 1'b1;
            byte_next     = in_byte;
            eoi_next      = in_eoi;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end
    end

    // Byte decode; stages run in order: after-quote, open field, lead, unquoted.
    always_comb
    begin
        mode_next = mode_reg;
        fc_next   = fc_reg;
        skip_next = skip_reg;
        done_next = done_reg;
        n         = 2'd0;
        kind_a[0] = KIND_CHAR;
        kind_a[1] = KIND_CHAR;
        char_a[0] = CH_NUL;
        char_a[1] = CH_NUL;
        aq_go     = 1'b0;
        open_go   = 1'b0;
        lead_go   = 1'b0;
        unq_go    = 1'b0;

        if (done_reg)
        begin
            n = 2'd0;
        end
        else if (eoi_reg || byte_reg == CH_NUL)
        begin
            if (mode_reg >= M_SEP && mode_reg <= M_POSTQ)
            begin
                kind_a[n[0]] = KIND_RECORD;
                n = n + 2'd1;
            end
            kind_a[n[0]] = KIND_STREAM;
            n = n + 2'd1;
            mode_next = M_IDLE;
            skip_next = 1'b0;
            done_next = 1'b1;
        end
        else
        begin
            case (mode_reg)
                M_SEP:
                begin
                    kind_a[n[0]] = KIND_FIELD;
                    n = n + 2'd1;
                    open_go = 1'b1;
                end
                M_LEAD:
                begin
                    lead_go = 1'b1;
                end
                M_UNQ:
                begin
                    unq_go = 1'b1;
                end
                M_QUOTED:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        mode_next = M_QCLOSE;
                    end
                    else
                    begin
                        kind_a[n[0]] = KIND_CHAR;
                        char_a[n[0]] = byte_reg;
                        n = n + 2'd1;
                    end
                end
                M_QCLOSE:
                begin
                    if (byte_reg == CH_QUOTE)
                    begin
                        kind_a[n[0]] = KIND_CHAR;
                        char_a[n[0]] = CH_QUOTE;
                        n = n + 2'd1;
                        mode_next = M_QUOTED;
                    end
                    else
                    begin
                        aq_go = 1'b1;
                    end
                end
                M_POSTQ:
                begin
                    aq_go = 1'b1;
                end
                default:
                begin
                    // Swallow one CR or LF right after a record-ending break.
                    if (skip_reg && brk)
                    begin
                        skip_next = 1'b0;
                        mode_next = M_IDLE;
                    end
                    else
                    begin
                        skip_next = 1'b0;
                        fc_next   = 8'd0;
                        open_go   = 1'b1;
                    end
                end
            endcase

            if (aq_go)
            begin
                if (byte_reg == CH_SPACE)
                begin
                    mode_next = M_POSTQ;
                end
                else if (byte_reg == sep_reg)
                begin
                    mode_next = M_SEP;
                end
                else if (brk)
                begin
                    kind_a[n[0]] = KIND_RECORD;
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    skip_next = 1'b1;
                end
                else
                begin
                    kind_a[n[0]] = KIND_FIELD;
                    n = n + 2'd1;
                    open_go = 1'b1;
                end
            end

            if (open_go)
            begin
                if (fc_next < COUNT_MAX)
                begin
                    fc_next = fc_next + 8'd1;
                end
                lead_go = 1'b1;
            end

            if (lead_go)
            begin
                if (byte_reg == CH_SPACE)
                begin
                    mode_next = M_LEAD;
                end
                else if (byte_reg == CH_QUOTE)
                begin
                    mode_next = M_QUOTED;
                end
                else
                begin
                    unq_go = 1'b1;
                end
            end

            if (unq_go)
            begin
                if (byte_reg == sep_reg)
                begin
                    mode_next = M_SEP;
                end
                else if (brk && !(expf_reg != 8'd0 && fc_next < expf_reg))
                begin
                    kind_a[n[0]] = KIND_RECORD;
                    n = n + 2'd1;
                    mode_next = M_IDLE;
                    skip_next = 1'b1;
                end
                else
                begin
                    kind_a[n[0]] = KIND_CHAR;
                    char_a[n[0]] = byte_reg;
                    n = n + 2'd1;
                    mode_next = M_UNQ;
                end
            end
        end
    end

    always_comb
    begin
        push.n       = fire ? n : 2'd0;
        push.e0.kind = kind_a[0];
        push.e0.ch   = char_a[0];
        push.e0.last = (n == 2'd1);
        push.e1.kind = kind_a[1];
        push.e1.ch   = char_a[1];
        push.e1.last = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg      <= SEP_RESET;
            expf_reg     <= 8'd0;
            in_valid_reg <= 1'b0;
            mode_reg     <= M_IDLE;
            fc_reg       <= 8'd0;
            skip_reg     <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            sep_reg      <= sep_next;
            expf_reg     <= expf_next;
            in_valid_reg <= in_valid_next;
            if (fire)
            begin
                mode_reg <= mode_next;
                fc_reg   <= fc_next;
                skip_reg <= skip_next;
                done_reg <= done_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        eoi_reg  <= eoi_next;
    end

    `CSVTOK_ASSERT_NOW(a_done_silent, fire && done_reg, push.n == 2'd0, "transfer after end of stream produced results")
    `CSVTOK_ASSERT_NEXT(a_end_sets_done, fire && (eoi_reg || byte_reg == CH_NUL), done_reg && mode_reg == M_IDLE, "end of stream did not close the parser")
    `CSVTOK_ASSERT_NEXT(a_record_idles, fire && push.n != 2'd0 && push.e0.kind == KIND_RECORD, mode_reg == M_IDLE, "record end left a record open")

endmodule
`default_nettype wire

### design/csvtok_fifo.sv
// Result queue: takes up to two results per cycle, hands out one per transfer.
`default_nettype none
module csvtok_fifo (
    input  wire                clk,
    input  wire                rst_n,
    input  csvtok_pkg::push_t  push,
    output logic               room,
    output logic               out_valid,
    input  wire                out_ready,
    output csvtok_pkg::res_t   out_res
);
    import csvtok_pkg::*;

    res_t             mem [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_reg, wr_next;
    logic [PTR_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;
    logic [PTR_W-1:0] wr_plus1;

    assign out_valid = (cnt_reg != '0);
    assign out_res   = mem[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for a worst-case pair of results.
    assign room      = (cnt_reg <= CNT_W'(FIFO_DEPTH - 2));
    assign wr_plus1  = wr_reg + PTR_W'(1);

    always_comb
    begin
        wr_next  = wr_reg + PTR_W'(push.n);
        rd_next  = pop ? rd_reg + PTR_W'(1) : rd_reg;
        cnt_next = cnt_reg + CNT_W'(push.n) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
        begin
            mem[wr_reg] <= push.e0;
        end
        if (push.n == 2'd2)
        begin
            mem[wr_plus1] <= push.e1;
        end
    end

endmodule
`default_nettype wire

### test/tb_csv_record_tokenizer.sv
// Testbench for the CSV record tokenizer: byte streams checked token by token.
`timescale 1ns / 100ps
module tb_csv_record_tokenizer;
    import csvtok_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 150;
    localparam int CHUNK_BYTES  = 55;
    localparam int REPORT_MAX   = 10;

    logic       clk = 1'b0;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_index;
    logic [7:0] cfg_wdata;

    csvtok_in_if  byte_ch ();
    csvtok_out_if token_ch ();

    csv_record_tokenizer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .rx        (byte_ch),
        .tx        (token_ch)
    );

    // separator / expected field count pairs swept by the random part
    logic [7:0] sep_table [12] = '{8'd44, 8'd59, CH_SPACE, CH_CR, CH_LF, CH_QUOTE,
                                   8'd255, 8'd9, 8'd1, CH_NUL, 8'd124, 8'd44};
    logic [7:0] exp_table [12] = '{8'd0, 8'd3, 8'd2, 8'd0, 8'd1, 8'd2,
                                   8'd255, 8'd4, 8'd0, 8'd1, 8'd3, 8'd0};

    // tokenizer state as predicted
    logic [7:0] sep_char;
    logic [7:0] fields_expected;
    logic [2:0] mode;
    logic [7:0] field_cnt;
    logic       skip_break;
    logic       stream_closed;

    res_t step_tokens[$];
    res_t expected_tokens[$];

    int   cycle_count    = 0;
    int   mismatch_count = 0;
    int   bytes_taken    = 0;
    int   send_idle_pct  = 19;
    int   recv_idle_pct  = 67;
    logic rx_hold        = 1'b0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic void emit_token(logic [1:0] kind, logic [7:0] ch);
        res_t tok;
        tok.kind = kind;
        tok.ch   = (kind == KIND_CHAR) ? ch : CH_NUL;
        tok.last = 1'b0;
        if (step_tokens.size() < 2)
            step_tokens.insert(step_tokens.size(), tok);
    endfunction

    function automatic logic is_line_break(logic [7:0] b);
        return b == CH_CR || b == CH_LF;
    endfunction

    function automatic void close_record();
        emit_token(KIND_RECORD, CH_NUL);
        mode       = M_IDLE;
        skip_break = 1'b1;
    endfunction

    function automatic void take_unquoted(logic [7:0] b);
        if (b == sep_char)
            mode = M_SEP;
        else if (is_line_break(b) && !(fields_expected != 0 && field_cnt < fields_expected))
            close_record();
        else
        begin
            emit_token(KIND_CHAR, b);
            mode = M_UNQ;
        end
    endfunction

    function automatic void take_leading(logic [7:0] b);
        if (b == CH_SPACE)
            mode = M_LEAD;
        else if (b == CH_QUOTE)
            mode = M_QUOTED;
        else
            take_unquoted(b);
    endfunction

    function automatic void open_field(logic [7:0] b);
        if (field_cnt < COUNT_MAX)
            field_cnt = field_cnt + 8'd1;
        take_leading(b);
    endfunction

    function automatic void take_after_quote(logic [7:0] b);
        if (b == CH_SPACE)
            mode = M_POSTQ;
        else if (b == sep_char)
            mode = M_SEP;
        else if (is_line_break(b))
            close_record();
        else
        begin
            emit_token(KIND_FIELD, CH_NUL);
            open_field(b);
        end
    endfunction

    task automatic predict_tokens(input logic [7:0] b, input logic eoi);
        step_tokens.delete();
        if (stream_closed)
            return;
        if (eoi || b == CH_NUL)
        begin
            if (mode >= M_SEP && mode <= M_POSTQ)
                emit_token(KIND_RECORD, CH_NUL);
            emit_token(KIND_STREAM, CH_NUL);
            mode          = M_IDLE;
            skip_break    = 1'b0;
            stream_closed = 1'b1;
        end
        else
        begin
            case (mode)
                M_SEP:
                begin
                    emit_token(KIND_FIELD, CH_NUL);
                    open_field(b);
                end
                M_LEAD:
                    take_leading(b);
                M_UNQ:
                    take_unquoted(b);
                M_QUOTED:
                    if (b == CH_QUOTE)
                        mode = M_QCLOSE;
                    else
                        emit_token(KIND_CHAR, b);
                M_QCLOSE:
                    if (b == CH_QUOTE)
                    begin
                        emit_token(KIND_CHAR, CH_QUOTE);
                        mode = M_QUOTED;
                    end
                    else
                        take_after_quote(b);
                M_POSTQ:
                    take_after_quote(b);
                default:
                    // swallow one CR or LF right after a record-ending break
                    if (skip_break && is_line_break(b))
                    begin
                        skip_break = 1'b0;
                        mode       = M_IDLE;
                    end
                    else
                    begin
                        skip_break = 1'b0;
                        field_cnt  = 8'd0;
                        open_field(b);
                    end
            endcase
        end
        if (step_tokens.size() > 0)
            step_tokens[step_tokens.size() - 1].last = 1'b1;
        foreach (step_tokens[i])
            expected_tokens.insert(expected_tokens.size(), step_tokens[i]);
    endtask

    task automatic report_mismatch(input string what, input res_t want, input res_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
        begin
            $display("mismatch (%s) at %0t: expected kind %0d char %02h last %0d",
                     what, $time, want.kind, want.ch, want.last);
            $display("    got kind %0d char %02h last %0d", got.kind, got.ch, got.last);
        end
    endtask

    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && token_ch.valid && token_ch.ready)
        begin
            got.kind = token_ch.out_kind;
            got.ch   = token_ch.out_char;
            got.last = token_ch.last;
            if (expected_tokens.size() == 0)
                report_mismatch("no token pending", '0, got);
            else
            begin
                want = expected_tokens.pop_front();
                if (got.kind !== want.kind || got.ch !== want.ch || got.last !== want.last)
                    report_mismatch("wrong token", want, got);
            end
        end
    end

    // receiver: random stalls, or a long hold-off while rx_hold is set
    initial
    begin
        token_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            token_ch.ready <= rx_hold ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic eoi);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid        = 1'b1;
        byte_ch.in_byte      = b;
        byte_ch.end_of_input = eoi;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        if (!stream_closed)
            bytes_taken++;
        predict_tokens(b, eoi);
    endtask

    // drop valid, let every token drain and the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        byte_ch.valid = 1'b0;
        while (expected_tokens.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == REG_SEPARATOR)
            sep_char = value;
        else
            fields_expected = value;
    endtask

    task automatic apply_setting(input logic [7:0] sep, input logic [7:0] nfields);
        wait_idle();
        write_reg(REG_SEPARATOR, sep);
        write_reg(REG_EXPECTED, nfields);
    endtask

    // never zero: a zero byte would close the stream early
    function automatic logic [7:0] pick_content();
        case ($urandom_range(9))
            0: return 8'($urandom_range(1, 255));
            1: return $urandom_range(1) ? CH_CR : CH_LF;
            2: return CH_SPACE;
            default: return 8'($urandom_range(8'h21, 8'h7e));
        endcase
    endfunction

    function automatic logic [7:0] field_break();
        return (sep_char == CH_NUL) ? 8'd44 : sep_char;
    endfunction

    task automatic send_line_break();
        case ($urandom_range(5))
            0: send_byte(CH_LF, 1'b0);
            1: send_byte(CH_CR, 1'b0);
            2:
            begin
                send_byte(CH_CR, 1'b0);
                send_byte(CH_LF, 1'b0);
            end
            3:
            begin
                send_byte(CH_LF, 1'b0);
                send_byte(CH_CR, 1'b0);
            end
            4:
            begin
                send_byte(CH_CR, 1'b0);
                send_byte(CH_CR, 1'b0);
            end
            default:
                repeat (3) send_byte(CH_LF, 1'b0);
        endcase
    endtask

    task automatic send_field();
        repeat ($urandom_range(3) == 0 ? $urandom_range(1, 2) : 0) send_byte(CH_SPACE, 1'b0);
        case ($urandom_range(5))
            0: ;
            1, 2:
            begin
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(4))
                begin
                    case ($urandom_range(7))
                        0:
                        begin
                            send_byte(CH_QUOTE, 1'b0);
                            send_byte(CH_QUOTE, 1'b0);
                        end
                        1: send_byte(field_break(), 1'b0);
                        default: send_byte(pick_content(), 1'b0);
                    endcase
                end
                send_byte(CH_QUOTE, 1'b0);
                repeat ($urandom_range(2)) send_byte(CH_SPACE, 1'b0);
                if ($urandom_range(5) == 0)
                    send_byte(pick_content(), 1'b0);
            end
            default:
                repeat ($urandom_range(1, 4)) send_byte(pick_content(), 1'b0);
        endcase
    endtask

    task automatic send_record();
        int lo;
        int hi;
        int n;
        if ($urandom_range(9) == 0)
        begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(1, 255)), 1'b0);
        end
        else
        begin
            if (fields_expected == 0)
                n = $urandom_range(1, 5);
            else
            begin
                lo = (fields_expected > 1) ? fields_expected - 1 : 1;
                hi = (fields_expected + 1 > 8) ? 8 : fields_expected + 1;
                if (lo > hi)
                    lo = hi;
                n = $urandom_range(lo, hi);
            end
            for (int i = 0; i < n; i++)
            begin
                send_field();
                if (i < n - 1)
                    send_byte(field_break(), 1'b0);
            end
            send_line_break();
        end
    endtask

    task automatic test_directed();
        logic [7:0] seq[$];
        // quoted field with a doubled quote, trailing spaces, extreme bytes,
        // CR LF with the LF swallowed, a stray byte after a closing quote
        seq = '{CH_SPACE, CH_QUOTE, 8'h61, CH_QUOTE, CH_QUOTE, 8'hff, CH_QUOTE,
                CH_SPACE, CH_SPACE, 8'h2c, 8'h7f, 8'h01, 8'h80, CH_CR, CH_LF,
                CH_QUOTE, 8'h71, CH_QUOTE, 8'h7a, 8'h2c, CH_QUOTE, CH_QUOTE, CH_LF};
        foreach (seq[i])
            send_byte(seq[i], 1'b0);
        // line break kept as content while the record is short
        apply_setting(8'd59, 8'd2);
        seq = '{8'h61, CH_LF, 8'd59, 8'h63, CH_CR, CH_LF};
        foreach (seq[i])
            send_byte(seq[i], 1'b0);
    endtask

    task automatic test_count_saturation();
        apply_setting(8'd44, COUNT_MAX);
        repeat (300) send_byte(8'd44, 1'b0);
        send_byte(8'h61, 1'b0);
        send_byte(CH_LF, 1'b0);
    endtask

    task automatic test_backpressure();
        apply_setting(8'd44, 8'd0);
        send_idle_pct = 0;
        fork
            begin
                rx_hold <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
                rx_hold <= 1'b0;
            end
            repeat (12) send_record();
        join
    endtask

    task automatic test_random_records();
        int goal;
        for (int phase = 0; phase < 3; phase++)
        begin
            send_idle_pct = (phase == 0) ? 19 : (phase == 1) ? 67 : 0;
            recv_idle_pct = (phase == 0) ? 67 : (phase == 1) ? 19 : 0;
            for (int k = 0; k < 4; k++)
            begin
                apply_setting(sep_table[phase * 4 + k], exp_table[phase * 4 + k]);
                goal = bytes_taken + CHUNK_BYTES;
                while (bytes_taken < goal)
                    send_record();
            end
        end
    endtask

    task automatic test_end_of_stream();
        apply_setting(8'd44, 8'd0);
        send_idle_pct = 19;
        recv_idle_pct = 67;
        send_byte(8'h7a, 1'b0);
        send_byte(CH_LF, 1'b0);
        case ($urandom_range(4))
            0:
            begin
                send_byte(8'h61, 1'b0);
                send_byte(8'd44, 1'b0);
            end
            1:
            begin
                send_byte(CH_QUOTE, 1'b0);
                send_byte(8'h78, 1'b0);
            end
            2:
            begin
                send_byte(CH_SPACE, 1'b0);
                send_byte(CH_SPACE, 1'b0);
            end
            3: ;
            default:
            begin
                send_byte(8'h62, 1'b0);
                send_byte(8'h63, 1'b0);
            end
        endcase
        if ($urandom_range(1))
            send_byte(8'($urandom_range(255)), 1'b1);
        else
            send_byte(CH_NUL, 1'b0);
        // dropped once the stream is closed
        send_byte(CH_NUL, 1'b1);
        repeat (3) send_byte(8'($urandom_range(1, 255)), 1'b0);
    endtask

    initial
    begin
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = REG_SEPARATOR;
        cfg_wdata            = 8'd0;
        byte_ch.valid        = 1'b0;
        byte_ch.in_byte      = 8'd0;
        byte_ch.end_of_input = 1'b0;
        sep_char             = SEP_RESET;
        fields_expected      = 8'd0;
        mode                 = M_IDLE;
        field_cnt            = 8'd0;
        skip_break           = 1'b0;
        stream_closed        = 1'b0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_count_saturation();
        test_backpressure();
        test_random_records();
        test_end_of_stream();

        wait_idle();
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

### filelist.f
+incdir+design
design/csvtok_pkg.sv
design/csvtok_if.sv
design/csvtok_core.sv
design/csvtok_fifo.sv
design/csv_record_tokenizer.sv
test/tb_csv_record_tokenizer.sv
